>>> rtl/ils_pkg.sv
// Shared constants, codes and types of the indexed list store.
package ils_pkg;

   // Store geometry.
   localparam int DEPTH   = 256;
   localparam int VALUE_W = 32;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   // Fixed field widths of the request and response transfers.
   localparam int FUNC_W  = 3;
   localparam int POS_W   = 8;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 9;

   // Operation codes carried in the request.
   typedef enum logic [FUNC_W-1:0] {
      FN_APPEND = 3'd0,
      FN_INSERT = 3'd1,
      FN_SET    = 3'd2,
      FN_REMOVE = 3'd3,
      FN_GET    = 3'd4,
      FN_FIND   = 3'd5,
      FN_CLEAR  = 3'd6
   } func_type;

   // Status codes returned in the response.
   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_INDEX = 2'd1,
      STAT_NULL      = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_GET_WAIT,
      S_FIND,
      S_REM_HEAD,
      S_REM_SHIFT,
      S_INS_SHIFT,
      S_INS_PUT,
      S_FINISH
   } state_type;

   // Write port of the entry memory.
   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] data;
   } mem_wr_type;

   // Read port of the entry memory.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

endpackage

>>> rtl/ils_req_if.sv
// Request channel of the indexed list store: valid, ready and the request fields.
interface ils_req_if;
   logic                        valid;
   logic                        ready;
   logic [ils_pkg::FUNC_W-1:0]  func;
   logic [ils_pkg::POS_W-1:0]   position;
   logic [ils_pkg::DATA_W-1:0]  item_value;

   modport source (output valid, output func, output position, output item_value,
                   input ready);
   modport sink   (input valid, input func, input position, input item_value,
                   output ready);
endinterface

>>> rtl/ils_rsp_if.sv
// Response channel of the indexed list store: valid, ready and the result fields.
interface ils_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ils_pkg::STAT_W-1:0]  status;
   logic [ils_pkg::DATA_W-1:0]  read_value;
   logic                        found;
   logic [ils_pkg::POS_W-1:0]   found_index;
   logic [ils_pkg::LEN_W-1:0]   length;

   modport source (output valid, output status, output read_value, output found,
                   output found_index, output length, input ready);
   modport sink   (input valid, input status, input read_value, input found,
                   input found_index, input length, output ready);
endinterface

>>> rtl/ils_ram.sv
// Entry memory of the list: one write port and one registered read port.
module ils_ram (
   input  logic                             clock,
   input  ils_pkg::mem_wr_type              wr,
   input  ils_pkg::mem_rd_type              rd,
   output logic [ils_pkg::VALUE_W-1:0]      rd_data
);
   import ils_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port: the read data appears in the cycle after the read is enabled.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/indexed_list_store.sv
// Top level of the indexed list store: request decode, walk sequencer and response register.
//
// An ordered list of nonzero 32-bit words held in a single-port-per-direction memory of
// 256 entries, with a count of entries held. Each request transfer on req_chan carries one
// operation (append, insert, set, remove, get, find, clear) and produces exactly one
// response transfer on rsp_chan with status, read value, find result and the new length.
// A request is taken only while the sequencer is idle; one request is worked at a time.
// Response valid follows the request transfer through these steps:
//   append, set, clear, refused requests and unused codes: straight to the finishing step
//   get: a wait for the registered read, then the finishing step
//   find: a walk from the head that stops at the first hit or at the last entry
//   remove at index p: a walk from p that moves each entry above p down by one
//   insert at index p below count: a walk from the last entry down to p, then the new value
// The next request is taken in the cycle after the response register is loaded. The time an
// item takes is set by the walk through the entry memory, one entry read and one entry
// written per cycle.
// The response register holds a finished result while the receiver stalls; the next
// request is still taken and worked, and waits at its last step until the register frees.
// Synchronous reset empties the list and drops any pending response; the memory itself is
// not cleared, since only entries below the count are ever read.
module indexed_list_store (
   input logic       clock,
   input logic       reset,
   ils_req_if.sink   req_chan,
   ils_rsp_if.source rsp_chan
);
   import ils_pkg::*;

   // Sequencer and working state.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  walk_ff, walk_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   status_type         st_ff, st_in;
   logic [VALUE_W-1:0] rdv_ff, rdv_in;
   logic               hit_ff, hit_in;
   logic [ADDR_W-1:0]  hit_idx_ff, hit_idx_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [LEN_W-1:0]   rsp_length_ff, rsp_length_in;

   // Memory ports.
   mem_wr_type         mem_wr;
   mem_rd_type         mem_rd;
   logic [VALUE_W-1:0] rd_data;

   // Decode signals.
   logic               accept;
   func_type           fn;
   logic [CNT_W-1:0]   pos_ext;
   logic [VALUE_W-1:0] req_val;
   logic               val_zero;
   logic               full;
   status_type         req_status;
   logic               req_ok;
   logic [CNT_W-1:0]   walk_ext;
   logic               walk_next_last;
   logic               walk_skip_last;
   logic               ins_last;
   logic               find_hit;
   logic               slot_free;

   ils_ram u_ram (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (rd_data)
   );

   // Request handshake and field decode.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign fn             = func_type'(req_chan.func);
   assign pos_ext        = CNT_W'(req_chan.position);
   assign req_val        = VALUE_W'(req_chan.item_value);
   assign val_zero       = (req_val == '0);
   assign full           = (count_ff == CNT_W'(DEPTH));

   // Refusal checks, in the order null value, index, full.
   always_comb begin
      req_status = STAT_OK;
      case (fn)
         FN_APPEND: begin
            if (val_zero)                req_status = STAT_NULL;
            else if (full)               req_status = STAT_FULL;
         end
         FN_INSERT: begin
            if (val_zero)                req_status = STAT_NULL;
            else if (pos_ext > count_ff) req_status = STAT_BAD_INDEX;
            else if (full)               req_status = STAT_FULL;
         end
         FN_SET: begin
            if (val_zero)                 req_status = STAT_NULL;
            else if (pos_ext >= count_ff) req_status = STAT_BAD_INDEX;
         end
         FN_REMOVE, FN_GET: begin
            if (pos_ext >= count_ff)      req_status = STAT_BAD_INDEX;
         end
         FN_FIND: begin
            if (val_zero)                 req_status = STAT_NULL;
         end
         default: req_status = STAT_OK;
      endcase
   end

   assign req_ok = (req_status == STAT_OK);

   // Walk end conditions and the response slot.
   assign walk_ext       = CNT_W'(walk_ff);
   assign walk_next_last = ((walk_ext + CNT_W'(1)) == count_ff);
   assign walk_skip_last = ((walk_ext + CNT_W'(2)) == count_ff);
   assign ins_last       = (walk_ff == pos_ff);
   assign find_hit       = (rd_data == val_ff);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (fn)
                  FN_INSERT: begin
                     if (req_ok && (pos_ext != count_ff)) state_in = S_INS_SHIFT;
                     else                                 state_in = S_FINISH;
                  end
                  FN_REMOVE: state_in = req_ok ? S_REM_HEAD : S_FINISH;
                  FN_GET:    state_in = req_ok ? S_GET_WAIT : S_FINISH;
                  FN_FIND: begin
                     if (req_ok && (count_ff != '0)) state_in = S_FIND;
                     else                            state_in = S_FINISH;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_GET_WAIT: state_in = S_FINISH;
         S_FIND: begin
            if (find_hit || walk_next_last) state_in = S_FINISH;
         end
         S_REM_HEAD: state_in = walk_next_last ? S_FINISH : S_REM_SHIFT;
         S_REM_SHIFT: begin
            if (walk_skip_last) state_in = S_FINISH;
         end
         S_INS_SHIFT: begin
            if (ins_last) state_in = S_INS_PUT;
         end
         S_INS_PUT: state_in = S_FINISH;
         S_FINISH: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory accesses and working register updates per state.
   always_comb begin
      count_in      = count_ff;
      walk_in       = walk_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      st_in         = st_ff;
      rdv_in        = rdv_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_length_in = rsp_length_ff;
      mem_wr.en     = 1'b0;
      mem_wr.addr   = walk_ff;
      mem_wr.data   = rd_data;
      mem_rd.en     = 1'b0;
      mem_rd.addr   = walk_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in     = req_val;
               pos_in     = ADDR_W'(req_chan.position);
               st_in      = req_status;
               rdv_in     = '0;
               hit_in     = 1'b0;
               hit_idx_in = '0;
               case (fn)
                  FN_APPEND: begin
                     if (req_ok) begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = ADDR_W'(count_ff);
                        mem_wr.data = req_val;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  FN_INSERT: begin
                     if (req_ok) begin
                        if (pos_ext == count_ff) begin
                           // Insert at the end needs no shift.
                           mem_wr.en   = 1'b1;
                           mem_wr.addr = ADDR_W'(req_chan.position);
                           mem_wr.data = req_val;
                           count_in    = count_ff + CNT_W'(1);
                        end else begin
                           // Start moving entries up from the last one.
                           mem_rd.en   = 1'b1;
                           mem_rd.addr = ADDR_W'(count_ff - CNT_W'(1));
                           walk_in     = ADDR_W'(count_ff - CNT_W'(1));
                        end
                     end
                  end
                  FN_SET: begin
                     if (req_ok) begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = ADDR_W'(req_chan.position);
                        mem_wr.data = req_val;
                     end
                  end
                  FN_REMOVE, FN_GET: begin
                     if (req_ok) begin
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = ADDR_W'(req_chan.position);
                        walk_in     = ADDR_W'(req_chan.position);
                     end
                  end
                  FN_FIND: begin
                     if (req_ok && (count_ff != '0)) begin
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = '0;
                        walk_in     = '0;
                     end
                  end
                  FN_CLEAR: count_in = '0;
                  default: count_in = count_ff;
               endcase
            end
         end
         S_GET_WAIT: rdv_in = rd_data;
         S_FIND: begin
            // The read data belongs to the entry at the walk address.
            if (find_hit) begin
               hit_in     = 1'b1;
               hit_idx_in = walk_ff;
            end else if (!walk_next_last) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = walk_ff + ADDR_W'(1);
               walk_in     = walk_ff + ADDR_W'(1);
            end
         end
         S_REM_HEAD: begin
            rdv_in = rd_data;
            if (walk_next_last) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = walk_ff + ADDR_W'(1);
            end
         end
         S_REM_SHIFT: begin
            // Move the entry above the walk address down by one.
            mem_wr.en   = 1'b1;
            mem_wr.addr = walk_ff;
            mem_wr.data = rd_data;
            if (walk_skip_last) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = walk_ff + ADDR_W'(2);
               walk_in     = walk_ff + ADDR_W'(1);
            end
         end
         S_INS_SHIFT: begin
            // Move the entry at the walk address up by one.
            mem_wr.en   = 1'b1;
            mem_wr.addr = walk_ff + ADDR_W'(1);
            mem_wr.data = rd_data;
            if (!ins_last) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = walk_ff - ADDR_W'(1);
               walk_in     = walk_ff - ADDR_W'(1);
            end
         end
         S_INS_PUT: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = pos_ff;
            mem_wr.data = val_ff;
            count_in    = count_ff + CNT_W'(1);
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_value_in  = DATA_W'(rdv_ff);
               rsp_found_in  = hit_ff;
               rsp_index_in  = POS_W'(hit_idx_ff);
               rsp_length_in = LEN_W'(count_ff);
            end
         end
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      st_ff         <= st_in;
      rdv_ff        <= rdv_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_length_ff <= rsp_length_in;
   end

   // Response channel.
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.found_index = rsp_index_ff;
   assign rsp_chan.length      = rsp_length_ff;

   // The count never passes the store depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count exceeds store depth");

   // A new response is only loaded from the finishing step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside the finishing step");

   // The walk never reads and writes the same entry in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_wr.en && mem_rd.en && (mem_wr.addr == mem_rd.addr)))
      else $error("read and write to the same entry in one cycle");

   // A clear transfer empties the list.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (fn == FN_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not empty the list");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the indexed list store, with a list predictor and random traffic.
`timescale 1ns / 100ps

module testbench;
   import ils_pkg::*;

   // Unused operation code; the block answers it without touching the list.
   localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

   // Two copies of the predicted list: one steers stimulus, one checks results.
   localparam int PLAN  = 0;
   localparam int CHECK = 1;

   localparam int TAIL_CYCLES  = 300;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int SHOWN_ERRORS = 10;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] item_value;
      logic              drain_first;
   } list_request_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] read_value;
      logic              found;
      logic [POS_W-1:0]  found_index;
      logic [LEN_W-1:0]  length;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   reset_cycles = 0;

   // Request and response channels with locally held drive values.
   ils_req_if req_bus ();
   ils_rsp_if rsp_bus ();

   logic              req_valid    = 1'b0;
   logic [FUNC_W-1:0] req_func     = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic [DATA_W-1:0] req_value    = '0;
   logic              rsp_ready    = 1'b0;

   assign req_bus.valid      = req_valid;
   assign req_bus.func       = req_func;
   assign req_bus.position   = req_position;
   assign req_bus.item_value = req_value;
   assign rsp_bus.ready      = rsp_ready;

   indexed_list_store dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predicted list contents and lengths.
   logic [VALUE_W-1:0] shadow_entries [2][DEPTH];
   int unsigned        shadow_count [2] = '{0, 0};

   list_request_type pending_requests [$];
   list_result_type  expected_results [$];
   list_request_type next_request;
   list_result_type  expected_now;

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  result_count   = 0;
   int  error_count    = 0;
   logic drain_next    = 1'b0;

   int  gap_left       = 0;
   int  gap_stretch    = 0;
   bit  gap_quiet      = 1'b0;
   int  stall_left     = 0;
   int  stall_stretch  = 0;
   bit  stall_quiet    = 1'b0;

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hold reset at the start, counting rising edges in reset_cycles, then release it.
   always @(posedge clock) begin
      if (reset) begin
         if (reset_cycles == 9) reset <= 1'b0;
         reset_cycles <= reset_cycles + 1;
      end
   end

   // Apply one operation to a copy of the list and return the response it should give.
   function automatic list_result_type apply_list_op(input int copy,
         input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
         input logic [DATA_W-1:0] val);
      list_result_type res;
      int unsigned     cnt;
      int              i;
      res = '0;
      res.status = STAT_OK;
      cnt = shadow_count[copy];
      case (fn)
         FN_APPEND: begin
            if (val == '0) res.status = STAT_NULL;
            else if (cnt >= DEPTH) res.status = STAT_FULL;
            else begin
               shadow_entries[copy][cnt] = val;
               cnt++;
            end
         end
         FN_INSERT: begin
            if (val == '0) res.status = STAT_NULL;
            else if (pos > cnt) res.status = STAT_BAD_INDEX;
            else if (cnt >= DEPTH) res.status = STAT_FULL;
            else begin
               for (i = int'(cnt); i > int'(pos); i--)
                  shadow_entries[copy][i] = shadow_entries[copy][i-1];
               shadow_entries[copy][pos] = val;
               cnt++;
            end
         end
         FN_SET: begin
            if (val == '0) res.status = STAT_NULL;
            else if (pos >= cnt) res.status = STAT_BAD_INDEX;
            else shadow_entries[copy][pos] = val;
         end
         FN_REMOVE: begin
            if (pos >= cnt) res.status = STAT_BAD_INDEX;
            else begin
               res.read_value = shadow_entries[copy][pos];
               for (i = int'(pos); i + 1 < int'(cnt); i++)
                  shadow_entries[copy][i] = shadow_entries[copy][i+1];
               cnt--;
            end
         end
         FN_GET: begin
            if (pos >= cnt) res.status = STAT_BAD_INDEX;
            else res.read_value = shadow_entries[copy][pos];
         end
         FN_FIND: begin
            if (val == '0) res.status = STAT_NULL;
            else begin
               for (i = 0; i < int'(cnt); i++) begin
                  if (!res.found && shadow_entries[copy][i] == val) begin
                     res.found = 1'b1;
                     res.found_index = i[POS_W-1:0];
                  end
               end
            end
         end
         FN_CLEAR: cnt = 0;
         default: ;
      endcase
      shadow_count[copy] = cnt;
      res.length = cnt[LEN_W-1:0];
      return res;
   endfunction

   // Wait length for one handshake; runs of zero waits and runs of random waits follow at random.
   function automatic int draw_wait(inout int stretch_left, inout bit quiet);
      if (stretch_left == 0) begin
         quiet = ($urandom_range(0, 2) == 0);
         stretch_left = $urandom_range(10, 60);
      end
      stretch_left--;
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   // Queue a request and advance the planning copy of the list.
   function automatic void queue_request(input logic [FUNC_W-1:0] fn,
         input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] val);
      list_request_type item;
      item.func = fn;
      item.position = pos;
      item.item_value = val;
      item.drain_first = drain_next;
      drain_next = 1'b0;
      void'(apply_list_op(PLAN, fn, pos, val));
      pending_requests.push_back(item);
      queued_count++;
   endfunction

   // Values: some null, some already in the list, some small repeats, mostly random words.
   function automatic logic [DATA_W-1:0] pick_value();
      int unsigned cnt;
      int unsigned sel;
      cnt = shadow_count[PLAN];
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel <= 2 && cnt != 0) return shadow_entries[PLAN][$urandom_range(0, cnt - 1)];
      if (sel == 3) return DATA_W'($urandom_range(1, 4));
      return $urandom();
   endfunction

   // Positions: mostly inside the valid range, sometimes anywhere in the field.
   function automatic logic [POS_W-1:0] pick_position(input int unsigned top);
      if (top == 0 || $urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 255));
      return POS_W'($urandom_range(0, top - 1));
   endfunction

   // One random operation with position and value suited to the current list.
   function automatic void queue_mixed();
      int unsigned       cnt;
      int unsigned       pick;
      int unsigned       top;
      logic [FUNC_W-1:0] fn;
      cnt = shadow_count[PLAN];
      pick = $urandom_range(0, 99);
      if (pick < 20) fn = FN_APPEND;
      else if (pick < 35) fn = FN_INSERT;
      else if (pick < 47) fn = FN_SET;
      else if (pick < 62) fn = FN_REMOVE;
      else if (pick < 75) fn = FN_GET;
      else if (pick < 94) fn = FN_FIND;
      else if (pick < 97) fn = FN_CLEAR;
      else fn = FN_UNUSED;
      if (fn == FN_INSERT) top = (cnt < DEPTH) ? cnt + 1 : DEPTH;
      else top = cnt;
      queue_request(fn, pick_position(top), pick_value());
   endfunction

   // Fill the store to the top, work on the full list, then empty it.
   function automatic void queue_fill_phase();
      while (shadow_count[PLAN] < DEPTH) begin
         if ($urandom_range(0, 15) == 0) queue_mixed();
         else queue_request(FN_APPEND, POS_W'($urandom_range(0, 255)), pick_value());
      end
      repeat (30) queue_mixed();
      queue_request(FN_CLEAR, POS_W'($urandom_range(0, 255)), $urandom());
   endfunction

   // Request driver: present queued items with random gaps, predict on each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_bus.ready) begin
            expected_results.push_back(apply_list_op(CHECK, req_func, req_position, req_value));
            accepted_count++;
         end
         if (!req_valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first && expected_results.size() != 0)) begin
               next_request = pending_requests.pop_front();
               req_func     <= next_request.func;
               req_position <= next_request.position;
               req_value    <= next_request.item_value;
               req_valid    <= 1'b1;
               gap_left = draw_wait(gap_stretch, gap_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random stalls, compare every transfer with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= SHOWN_ERRORS)
                  $display("unexpected result %0d: status %0d length %0d",
                           result_count, rsp_bus.status, rsp_bus.length);
            end else begin
               expected_now = expected_results.pop_front();
               if (rsp_bus.status !== expected_now.status ||
                   rsp_bus.read_value !== expected_now.read_value ||
                   rsp_bus.found !== expected_now.found ||
                   rsp_bus.found_index !== expected_now.found_index ||
                   rsp_bus.length !== expected_now.length) begin
                  error_count++;
                  if (error_count <= SHOWN_ERRORS)
                     $display("mismatch on result %0d: status %0d/%0d read_value %h/%h ",
                              result_count, expected_now.status, rsp_bus.status,
                              expected_now.read_value, rsp_bus.read_value,
                              "found %0d/%0d found_index %0d/%0d length %0d/%0d (exp/got)",
                              expected_now.found, rsp_bus.found,
                              expected_now.found_index, rsp_bus.found_index,
                              expected_now.length, rsp_bus.length);
               end
            end
            stall_left = draw_wait(stall_stretch, stall_quiet);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus plan, then wait for the last result and report.
   initial begin
      int target;
      int phase;

      // Empty list: every index refused, find misses, null checked before index.
      queue_request(FN_GET, 8'd0, 32'd5);
      queue_request(FN_REMOVE, 8'd0, 32'd0);
      queue_request(FN_SET, 8'd0, 32'd5);
      queue_request(FN_FIND, 8'd255, 32'd5);
      queue_request(FN_APPEND, 8'd0, 32'd0);
      queue_request(FN_INSERT, 8'd1, 32'd7);
      queue_request(FN_INSERT, 8'd255, 32'd0);

      // Build a short list by append and by insert at the head, the tail and the middle.
      queue_request(FN_APPEND, 8'd255, 32'hFFFF_FFFF);
      queue_request(FN_APPEND, 8'd0, 32'h0000_0001);
      queue_request(FN_INSERT, 8'd0, 32'h8000_0000);
      queue_request(FN_INSERT, 8'd3, 32'h0000_FFFF);
      queue_request(FN_INSERT, 8'd2, 32'h1234_5678);

      // Set, get and find at the edges of the list.
      queue_request(FN_SET, 8'd255, 32'd0);
      queue_request(FN_SET, 8'd255, 32'd9);
      queue_request(FN_SET, 8'd1, 32'hA5A5_A5A5);
      queue_request(FN_GET, 8'd0, 32'd0);
      queue_request(FN_GET, 8'd4, 32'hFFFF_FFFF);
      queue_request(FN_GET, 8'd5, 32'd0);
      queue_request(FN_FIND, 8'd0, 32'h0000_0001);
      queue_request(FN_FIND, 8'd0, 32'h0000_FFFF);
      queue_request(FN_FIND, 8'd0, 32'd0);
      queue_request(FN_FIND, 8'd0, 32'h5A5A_5A5A);

      // Remove at head and tail, a refused remove, the unused code, then clear.
      queue_request(FN_REMOVE, 8'd0, 32'd0);
      queue_request(FN_REMOVE, 8'd3, 32'd0);
      queue_request(FN_REMOVE, 8'd255, 32'd0);
      queue_request(FN_UNUSED, 8'd255, 32'hFFFF_FFFF);
      queue_request(FN_CLEAR, 8'd0, 32'd0);
      queue_request(FN_GET, 8'd0, 32'd0);

      // Random phases; each phase starts once the block has answered everything.
      target = queued_count + 1200;
      for (phase = 0; queued_count < target; phase++) begin
         drain_next = 1'b1;
         if (phase == 1 || phase == 5) queue_fill_phase();
         else repeat (120) queue_mixed();
      end

      while (accepted_count != queued_count) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("indexed_list_store verification clean");
      end else begin
         $display("indexed_list_store verification failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(64'd8 * LIMIT_CYCLES);
      $display("indexed_list_store verification failed");
      $finish;
   end

endmodule
